[rtl/sscnt_pkg.sv]
`timescale 1ns / 1ps

package sscnt_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 5;
    localparam int PAT_BYTES  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

    // One accepted request as seen by the control logic
    typedef struct packed {
        logic take;       // request accepted this cycle
        logic eot;        // request is an end-of-text marker
        logic window_eq;  // every active cell matches its pattern byte
    } t_step;

endpackage

[rtl/sscnt_cell.sv]
`timescale 1ns / 1ps

module sscnt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic                       i_clear,
    input  logic [sscnt_pkg::CHAR_W-1:0] i_char,
    input  logic [sscnt_pkg::CHAR_W-1:0] i_expect,
    input  logic                       i_active,
    output logic [sscnt_pkg::CHAR_W-1:0] o_char,
    output logic                       o_eq
);
    import sscnt_pkg::*;

    logic [CHAR_W-1:0] r_char;

    // Hold one window byte, take the neighbor's byte on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_char <= '0;
        end else if (i_shift) begin
            r_char <= i_char;
        end
    end

    // Compare the byte that this shift brings in; inactive cells always agree
    assign o_eq   = !i_active || (i_char == i_expect);
    assign o_char = r_char;

endmodule

[rtl/sscnt_ctrl.sv]
`timescale 1ns / 1ps

module sscnt_ctrl #(
    parameter int MAX_PATTERN = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sscnt_pkg::t_step               i_step,
    input  logic [sscnt_pkg::LEN_W-1:0]    i_len,
    input  logic                           i_out_ready,
    output logic                           o_in_ready,
    output logic                           o_valid,
    output logic                           o_match,
    output logic                           o_done,
    output logic                           o_found,
    output logic [sscnt_pkg::OUT_W-1:0]    o_first,
    output logic [sscnt_pkg::OUT_W-1:0]    o_count
);
    import sscnt_pkg::*;

    localparam int SINCE_W = $clog2(MAX_PATTERN + 1);
    localparam logic [SINCE_W-1:0] SINCE_MAX = SINCE_W'(MAX_PATTERN);

    logic [INDEX_BITS-1:0] r_pos,   n_pos;
    logic [SINCE_W-1:0]    r_since, n_since;
    logic                  r_found, n_found;
    logic [INDEX_BITS-1:0] r_first, n_first;
    logic [OUT_W-1:0]      r_count, n_count;

    logic                  r_valid;
    logic                  r_match, r_done, r_out_found;
    logic [OUT_W-1:0]      r_out_first, r_out_count;

    logic [SINCE_W-1:0]    w_since_inc;
    logic                  w_hit;
    logic [63:0]           w_first_wide;

    // Accept while the output register is empty or being drained
    assign o_in_ready = !r_valid || i_out_ready;

    // Match decision and text state update
    always_comb begin
        w_since_inc = (r_since < SINCE_MAX) ? r_since + SINCE_W'(1) : r_since;
        w_hit = (i_len != '0) && (LEN_W'(w_since_inc) >= i_len) && i_step.window_eq;

        n_pos   = r_pos;
        n_since = r_since;
        n_found = r_found;
        n_first = r_first;
        n_count = r_count;
        if (i_step.take) begin
            if (i_step.eot) begin
                n_pos   = '0;
                n_since = '0;
                n_found = 1'b0;
                n_first = '0;
                n_count = '0;
            end else begin
                n_pos   = r_pos + INDEX_BITS'(1);
                n_since = w_hit ? '0 : w_since_inc;
                if (w_hit) begin
                    if (r_count != '1) begin
                        n_count = r_count + OUT_W'(1);
                    end
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_first = r_pos - INDEX_BITS'(i_len) + INDEX_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_since <= '0;
            r_found <= 1'b0;
            r_first <= '0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_since <= n_since;
            r_found <= n_found;
            r_first <= n_first;
            r_count <= n_count;
        end
    end

    // Output register: end of text reports totals before clearing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step.take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.take) begin
            r_done <= i_step.eot;
            if (i_step.eot) begin
                r_match     <= 1'b0;
                r_out_found <= r_found;
                r_out_first <= r_found ? w_first_wide[OUT_W-1:0] : '0;
                r_out_count <= r_count;
            end else begin
                r_match     <= w_hit;
                r_out_found <= n_found;
                r_out_first <= n_found ? w_first_wide[OUT_W-1:0] : '0;
                r_out_count <= n_count;
            end
        end
    end

    // The first index never changes on the step that reports it, except when set
    assign w_first_wide = i_step.eot ? 64'(r_first) : 64'(n_first);

    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_done  = r_done;
    assign o_found = r_out_found;
    assign o_first = r_out_first;
    assign o_count = r_out_count;

    // End of text is reported in the next cycle and leaves a cleared text state
    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.take && i_step.eot |=> r_valid && r_done && !r_match
            && !r_found && (r_count == '0) && (r_pos == '0))
        else $error("end of text not reported or state not cleared");

    // A counted match implies found and a nonzero count
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_match |-> r_out_found && (r_out_count != '0) && !r_done)
        else $error("match reported without found flag or count");

    // First index reads zero until a match is found
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out_found |-> (r_out_first == '0) && (r_out_count == '0))
        else $error("first index or count nonzero before any match");

    // The since counter is cleared on every counted match
    a_since_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.take && !i_step.eot && w_hit |=> (r_since == '0))
        else $error("since counter not cleared after a match");

    // The since counter never passes its saturation value
    a_since_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_since <= SINCE_MAX)
        else $error("since counter out of range");

endmodule

[rtl/substring_search_count.sv]
`timescale 1ns / 1ps

// Streaming substring counter. Text characters enter one per cycle on the
// slave stream; tlast marks the end-of-text request, which carries no
// character. The last MAX_PATTERN characters sit in a row of cells, each
// comparing its byte with the pattern byte aligned to it, so a match is
// decided in the cycle a character is taken and its result sits in the
// output register in the cycle after. Matches are counted leftmost and
// non-overlapping; the end-of-text result reports found, first start
// index and saturating count, then clears the text state. One request is
// taken every cycle as long as the master side drains results; the input
// stalls only while the single output register holds an untaken result.
// Configuration (pattern length and the 16 pattern bytes) is to be written by the user
// through the plain write port only while the stream is idle; the block does not enforce it.
module substring_search_count #(
    parameter int MAX_PATTERN = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sscnt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sscnt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] text_char
    input  logic [sscnt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,   // end_of_text
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] match_here, [1] found, [33:2] first_index, [65:34] match_count, zero pad
    output logic [sscnt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast    // text_done
);
    import sscnt_pkg::*;

    logic [LEN_W-1:0]          r_len;
    logic [CFG_DATA_W-1:0]     r_pat_low;
    logic [CFG_DATA_W-1:0]     r_pat_high;

    logic [LEN_W-1:0]          w_act_len;
    logic [8*PAT_BYTES-1:0]    w_pat_flat;
    logic                      w_take;
    logic [CHAR_W-1:0]         w_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]    w_eq;
    t_step                     w_step;

    logic                      w_match, w_found;
    logic [OUT_W-1:0]          w_first, w_count;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_LEN:  r_len      <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                REG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the length to the window size
    assign w_act_len  = (r_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_len;
    assign w_pat_flat = {r_pat_high, r_pat_low};

    assign w_take   = s_axis_tvalid && s_axis_tready;
    assign w_chain[0] = s_axis_tdata[CHAR_W-1:0];

    // Row of window cells, newest character in cell 0
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [LEN_W-1:0]  w_idx;
        logic [CHAR_W-1:0] w_expect;
        logic              w_active;

        // Cell k lines up with pattern byte len-1-k
        assign w_idx    = w_act_len - LEN_W'(1) - LEN_W'(k);
        assign w_expect = w_pat_flat[w_idx[3:0]*8 +: 8];
        assign w_active = LEN_W'(k) < w_act_len;

        sscnt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_take && !s_axis_tlast),
            .i_clear  (w_take && s_axis_tlast),
            .i_char   (w_chain[k]),
            .i_expect (w_expect),
            .i_active (w_active),
            .o_char   (w_chain[k+1]),
            .o_eq     (w_eq[k])
        );
    end

    assign w_step.take      = w_take;
    assign w_step.eot       = s_axis_tlast;
    assign w_step.window_eq = &w_eq;

    sscnt_ctrl #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_len       (w_act_len),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_match     (w_match),
        .o_done      (m_axis_tlast),
        .o_found     (w_found),
        .o_first     (w_first),
        .o_count     (w_count)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {6'b0, w_count, w_first, w_found, w_match};

endmodule

[tb/tb_substring_search_count.sv]
`timescale 1ns / 1ps

module tb_substring_search_count;
    import sscnt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int TAIL_ITEMS     = 1000;
    localparam int LONG_HOLD      = 60;
    // Index with no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        bit        match_here;
        bit        text_done;
        bit        found;
        bit [31:0] first_index;
        bit [31:0] match_count;
    } t_search_result;

    // Predicts the counter and keeps the results still owed by the block
    class search_scoreboard;
        bit [LEN_W-1:0]      pat_len;
        bit [CFG_DATA_W-1:0] pat_low;
        bit [CFG_DATA_W-1:0] pat_high;
        bit [7:0]            window [PAT_BYTES];
        bit [31:0]           position;
        int unsigned         since;
        bit                  found;
        bit [31:0]           first_index;
        bit [31:0]           occurrences;
        t_search_result      pending [$];
        int unsigned         errors;

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LEN:  pat_len = data[LEN_W-1:0];
                REG_PATTERN_LOW:  pat_low = data;
                REG_PATTERN_HIGH: pat_high = data;
                default: ;
            endcase
        endfunction

        function bit [7:0] pattern_byte(int unsigned i);
            bit [63:0] word;
            word = (i < 8) ? pat_low : pat_high;
            return word[(i % 8) * 8 +: 8];
        endfunction

        // Lengths above the pattern size act as a full-size pattern
        function int unsigned active_len();
            return (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = '0;
            position    = '0;
            since       = 0;
            found       = 1'b0;
            first_index = '0;
            occurrences = '0;
        endfunction

        function void note_request(bit [7:0] ch, bit eot);
            t_search_result r;
            int unsigned    len;
            int unsigned    i;
            bit             hit;
            len = active_len();
            hit = 1'b0;
            if (eot) begin
                r.match_here  = 1'b0;
                r.text_done   = 1'b1;
                r.found       = found;
                r.first_index = first_index;
                r.match_count = occurrences;
                clear_text();
            end else begin
                // Shift the new character in at the newest end
                for (i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = ch;
                if (since < PAT_BYTES) since++;
                // Count only once a full pattern length has passed since the last match
                if (len != 0 && since >= len) begin
                    hit = 1'b1;
                    for (i = 0; i < len; i++)
                        if (window[len-1-i] != pattern_byte(i)) hit = 1'b0;
                end
                if (hit) begin
                    if (occurrences != '1) occurrences++;
                    if (!found) begin
                        found       = 1'b1;
                        first_index = position - len + 1;
                    end
                    since = 0;
                end
                position++;
                r.match_here  = hit;
                r.text_done   = 1'b0;
                r.found       = found;
                r.first_index = first_index;
                r.match_count = occurrences;
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string name, bit [31:0] exp_val, bit [31:0] act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(bit [M_TDATA_W-1:0] data, bit last);
            t_search_result e;
            if (pending.size() == 0) begin
                $display("%0t: result with none outstanding, expected nothing actual %0h/%0b",
                         $time, data, last);
                errors++;
            end else begin
                e = pending.pop_front();
                compare_field("match_here", 32'(e.match_here), 32'(data[0]));
                compare_field("text_done", 32'(e.text_done), 32'(last));
                compare_field("found", 32'(e.found), 32'(data[1]));
                compare_field("first_index", e.first_index, data[33:2]);
                compare_field("match_count", e.match_count, data[65:34]);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] text_char
    logic                  s_axis_tlast = 1'b0;  // end_of_text
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // [0] match_here, [1] found,
                                                // [33:2] first_index, [65:34] match_count
    logic                  m_axis_tlast;        // text_done

    search_scoreboard sb = new();
    int unsigned      items_sent = 0;

    substring_search_count u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request and hold it until taken; sometimes pause afterwards
    task automatic send_request(bit [7:0] ch, bit eot);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(ch, eot);
        items_sent++;
        if (items_sent < TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every owed result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic program_pattern(bit [63:0] len_word, bit [63:0] low, bit [63:0] high);
        bit [CFG_IDX_W-1:0]  idx [4];
        bit [CFG_DATA_W-1:0] val [4];
        int                  k;
        idx[0] = REG_PATTERN_LEN;  val[0] = len_word;
        idx[1] = REG_PATTERN_LOW;  val[1] = low;
        idx[2] = REG_SPARE;        val[2] = {$urandom, $urandom};
        idx[3] = REG_PATTERN_HIGH; val[3] = high;
        for (k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Text built mostly from pattern pieces so matches and near misses are common
    task automatic send_text(int unsigned n);
        int unsigned k;
        int unsigned len;
        int unsigned part;
        int unsigned sel;
        int unsigned j;
        len = sb.active_len();
        k = 0;
        while (k < n) begin
            sel = $urandom_range(0, 9);
            if (len != 0 && sel < 3) begin
                part = (sel == 0) ? $urandom_range(1, len) : len;
                for (j = 0; j < part; j++) send_request(sb.pattern_byte(j), 1'b0);
                k += part;
            end else if (len != 0 && sel < 7) begin
                send_request(sb.pattern_byte($urandom_range(0, len - 1)), 1'b0);
                k++;
            end else begin
                send_request(8'($urandom_range(0, 255)), 1'b0);
                k++;
            end
        end
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Result side: random short stalls, one long hold while requests keep coming
    initial begin
        int unsigned stall_left;
        int unsigned results_seen;
        bit          held_long;
        stall_left   = 0;
        results_seen = 0;
        held_long    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                results_seen++;
            end
            if (stall_left == 0 && !held_long && results_seen >= 300 && s_axis_tvalid) begin
                stall_left = LONG_HOLD;
                held_long  = 1'b1;
            end else if (stall_left == 0 && items_sent < TAIL_ITEMS &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("substring_search_count: mismatch");
        $finish;
    end

    initial begin
        bit [63:0]   len_word;
        bit [63:0]   noise;
        bit [127:0]  pat;
        bit [7:0]    sym_a;
        bit [7:0]    sym_b;
        int unsigned j;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern after reset: zero window equals zero pattern but never counts
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h3C, 1'b1);
        drain();

        // Zero-byte pattern of length two over a run of zeros: no overlap allowed
        program_pattern(64'd2, 64'd0, {$urandom, $urandom});
        repeat (5) send_request(8'h00, 1'b0);
        send_request(8'hA5, 1'b1);
        drain();

        // Oversized length with junk above it, full-size all-ones pattern
        noise    = {$urandom, $urandom};
        len_word = {noise[63:5], 5'd31};
        program_pattern(len_word, '1, '1);
        repeat (16) send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);
        drain();

        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len_word = 64'd0;
                1:       len_word = 64'd1;
                2:       len_word = 64'd16;
                3:       len_word = 64'($urandom_range(17, 31));
                default: len_word = 64'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                noise    = {$urandom, $urandom};
                len_word = {noise[63:5], len_word[4:0]};
            end
            // Two-symbol patterns repeat themselves and stress the non-overlap rule
            if ($urandom_range(0, 1) == 1) begin
                sym_a = 8'($urandom_range(0, 255));
                sym_b = 8'($urandom_range(0, 255));
                for (j = 0; j < 16; j++) pat[j*8 +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end else begin
                pat = {$urandom, $urandom, $urandom, $urandom};
            end
            program_pattern(len_word, pat[63:0], pat[127:64]);
            repeat ($urandom_range(1, 3)) send_text($urandom_range(0, 60));
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("substring_search_count: match");
        else
            $display("substring_search_count: mismatch");
        $finish;
    end

endmodule
